### sv/lzwd_pkg.sv
// Shared types and constants for the LZ window decompressor.
`default_nettype none
package lzwd_pkg;

  localparam int WIN_SIZE = 1024;
  localparam int WIN_AW   = $clog2(WIN_SIZE);
  localparam int FILL_W   = WIN_AW + 1;
  localparam int ADDR_W   = 18;
  localparam int IMG_W    = 19;
  localparam int ROW_W    = 10;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int OUT_DW   = 56;

  localparam logic [WIN_AW-1:0] PTR_START = WIN_AW'(958);
  localparam logic [LEN_W-1:0]  LEN_BIAS  = LEN_W'(3);
  localparam logic [7:0]        FLAG_MARK = 8'hFF;

  localparam logic [1:0] REG_IMAGE_BYTES   = 2'd0;
  localparam logic [1:0] REG_ROW_STRIDE    = 2'd1;
  localparam logic [1:0] REG_COLUMN_HEIGHT = 2'd2;
  localparam logic [1:0] REG_COLUMN_ORDER  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_CRD,
    ST_CWR
  } state_t;

  typedef enum logic [1:0] {
    TK_FLAG,
    TK_LIT,
    TK_HIGH,
    TK_LOW
  } tok_kind_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_KIND  = 2'd1,
    PH_LOW   = 2'd2
  } tok_phase_t;

  typedef struct packed {
    logic [IMG_W-1:0] image_bytes;
    logic [ROW_W-1:0] row_stride;
    logic [ROW_W-1:0] column_height;
    logic             column_order;
  } cfg_regs_t;

  typedef struct packed {
    logic take_token;
    logic emit;
    logic emit_lit;
    logic rd;
  } dp_cmd_t;

  typedef struct packed {
    tok_kind_t kind;
    logic      out_free;
    logic      copy_end;
  } dp_status_t;

endpackage
`default_nettype wire

### sv/lzwd_ctrl.sv
// Control state machine: token intake, literal emit and copy read/write sequencing.
`default_nettype none
module lzwd_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  lzwd_pkg::dp_status_t status,
  output lzwd_pkg::dp_cmd_t    cmd
);
  import lzwd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take_token = 1'b1;
          case (status.kind)
            TK_LIT:  state_nxt = ST_LIT;
            TK_LOW:  state_nxt = ST_CRD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LIT: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_lit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CRD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CWR;
      end
      ST_CWR: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = status.copy_end ? ST_IDLE : ST_CRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/lzwd_datapath.sv
// Datapath: token parsing, history window RAM, address generation and result register.
`default_nettype none
module lzwd_datapath #(
  parameter int MAX_IMAGE_BYTES = 262144,
  parameter int MAX_STRIDE      = 512
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  lzwd_pkg::cfg_regs_t           cfg,
  input  wire [lzwd_pkg::BYTE_W-1:0]    in_byte,
  input  lzwd_pkg::dp_cmd_t             cmd,
  output lzwd_pkg::dp_status_t          status,
  input  wire                           out_tready,
  output logic                          out_tvalid,
  output logic [lzwd_pkg::OUT_DW-1:0]   out_tdata,
  output logic                          out_tlast,
  output logic                          out_tuser
);
  import lzwd_pkg::*;

  // parse state
  logic [15:0]       flag_shift_r, flag_shift_nxt, flag_sh;
  tok_phase_t        phase_r, phase_nxt;
  logic [BYTE_W-1:0] pending_r, pending_nxt;
  tok_kind_t         kind;

  // copy and literal operands
  logic [BYTE_W-1:0] lit_r, lit_nxt;
  logic [WIN_AW-1:0] src_r, src_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  // image progress
  logic [IMG_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [ADDR_W-1:0] dest_r, dest_nxt;
  logic [ROW_W-1:0]  rows_r, rows_nxt;
  logic [WIN_AW-1:0] wptr_r, wptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // window RAM
  logic [BYTE_W-1:0] win_mem [WIN_SIZE];
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_ok_r;
  logic [WIN_AW-1:0] src_off;

  // pairing and result register
  logic              pair_half_r, pair_half_nxt;
  logic [BYTE_W-1:0] pair_val_r, pair_val_nxt;
  logic [ADDR_W-1:0] pair_addr_r, pair_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] o_first_val_r, o_first_val_nxt, o_sec_val_r, o_sec_val_nxt;
  logic [ADDR_W-1:0] o_first_addr_r, o_first_addr_nxt, o_sec_addr_r, o_sec_addr_nxt;
  logic              o_has2_r, o_has2_nxt, o_last_r, o_last_nxt, o_done_r, o_done_nxt;

  // emit arithmetic
  logic [IMG_W-1:0]  eff_img, bl_cur, img_m1;
  logic [ROW_W-1:0]  eff_h, eff_stride, rows_cur, rows_dec;
  logic [ADDR_W-1:0] emit_addr, step_addr;
  logic [BYTE_W-1:0] emit_val;
  logic              img_start, img_last, copy_end, byte_last, push;

  // effective configuration
  always_comb begin
    if (cfg.image_bytes == '0) begin
      eff_img = IMG_W'(1);
    end else if (32'(cfg.image_bytes) > 32'(MAX_IMAGE_BYTES)) begin
      eff_img = IMG_W'(MAX_IMAGE_BYTES);
    end else begin
      eff_img = cfg.image_bytes;
    end
    if (cfg.row_stride == '0) begin
      eff_stride = ROW_W'(1);
    end else if (32'(cfg.row_stride) > 32'(MAX_STRIDE)) begin
      eff_stride = ROW_W'(MAX_STRIDE);
    end else begin
      eff_stride = cfg.row_stride;
    end
    eff_h = (cfg.column_height == '0) ? ROW_W'(1) : cfg.column_height;
  end

  // token decode
  always_comb begin
    flag_sh = flag_shift_r >> 1;
    case (phase_r)
      PH_KIND: kind = flag_shift_r[0] ? TK_LIT : TK_HIGH;
      PH_LOW:  kind = TK_LOW;
      default: begin
        if (flag_sh[15:8] == 8'h00) begin
          kind = TK_FLAG;
        end else begin
          kind = flag_sh[0] ? TK_LIT : TK_HIGH;
        end
      end
    endcase
  end

  // byte emit
  always_comb begin
    img_start = (bytes_left_r == '0);
    bl_cur    = img_start ? eff_img : bytes_left_r;
    img_last  = (bl_cur == IMG_W'(1));
    copy_end  = img_last || (len_r == LEN_W'(1));
    byte_last = cmd.emit_lit || copy_end;
    emit_val  = cmd.emit_lit ? lit_r : (rd_ok_r ? rd_data_r : '0);
    emit_addr = img_start ? '0 : dest_r;
    rows_cur  = img_start ? eff_h : rows_r;
    rows_dec  = rows_cur - ROW_W'(1);
    img_m1    = eff_img - IMG_W'(1);
    step_addr = emit_addr + ADDR_W'(eff_stride);
    push      = cmd.emit && (pair_half_r || byte_last);
    src_off   = src_r - PTR_START;
  end

  always_comb begin
    flag_shift_nxt   = flag_shift_r;
    phase_nxt        = phase_r;
    pending_nxt      = pending_r;
    lit_nxt          = lit_r;
    src_nxt          = src_r;
    len_nxt          = len_r;
    bytes_left_nxt   = bytes_left_r;
    dest_nxt         = dest_r;
    rows_nxt         = rows_r;
    wptr_nxt         = wptr_r;
    fill_nxt         = fill_r;
    pair_half_nxt    = pair_half_r;
    pair_val_nxt     = pair_val_r;
    pair_addr_nxt    = pair_addr_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    o_first_val_nxt  = o_first_val_r;
    o_first_addr_nxt = o_first_addr_r;
    o_sec_val_nxt    = o_sec_val_r;
    o_sec_addr_nxt   = o_sec_addr_r;
    o_has2_nxt       = o_has2_r;
    o_last_nxt       = o_last_r;
    o_done_nxt       = o_done_r;

    if (cmd.take_token) begin
      case (kind)
        TK_FLAG: begin
          flag_shift_nxt = {FLAG_MARK, in_byte};
          phase_nxt      = PH_KIND;
        end
        TK_LIT: begin
          if (phase_r == PH_START) flag_shift_nxt = flag_sh;
          phase_nxt = PH_START;
          lit_nxt   = in_byte;
        end
        TK_HIGH: begin
          if (phase_r == PH_START) flag_shift_nxt = flag_sh;
          pending_nxt = in_byte;
          phase_nxt   = PH_LOW;
        end
        default: begin
          phase_nxt = PH_START;
          src_nxt   = {pending_r[1:0], in_byte};
          len_nxt   = LEN_W'(pending_r[7:2]) + LEN_BIAS;
        end
      endcase
    end

    if (cmd.emit) begin
      src_nxt        = src_r + WIN_AW'(1);
      len_nxt        = len_r - LEN_W'(1);
      bytes_left_nxt = bl_cur - IMG_W'(1);
      wptr_nxt       = wptr_r + WIN_AW'(1);
      fill_nxt       = (fill_r == FILL_W'(WIN_SIZE)) ? fill_r : fill_r + FILL_W'(1);
      if (cfg.column_order) begin
        if (rows_dec == '0) begin
          dest_nxt = step_addr - img_m1[ADDR_W-1:0];
          rows_nxt = eff_h;
        end else begin
          dest_nxt = step_addr;
          rows_nxt = rows_dec;
        end
      end else begin
        dest_nxt = emit_addr + ADDR_W'(1);
        rows_nxt = rows_cur;
      end

      if (push) begin
        out_valid_nxt    = 1'b1;
        o_first_val_nxt  = pair_half_r ? pair_val_r : emit_val;
        o_first_addr_nxt = pair_half_r ? pair_addr_r : emit_addr;
        o_sec_val_nxt    = pair_half_r ? emit_val : '0;
        o_sec_addr_nxt   = pair_half_r ? emit_addr : '0;
        o_has2_nxt       = pair_half_r;
        o_last_nxt       = byte_last;
        o_done_nxt       = img_last;
        pair_half_nxt    = 1'b0;
      end else begin
        pair_half_nxt = 1'b1;
        pair_val_nxt  = emit_val;
        pair_addr_nxt = emit_addr;
      end

      if (img_last) begin
        flag_shift_nxt = '0;
        phase_nxt      = PH_START;
        pending_nxt    = '0;
        bytes_left_nxt = '0;
        dest_nxt       = '0;
        rows_nxt       = '0;
        wptr_nxt       = PTR_START;
        fill_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_shift_r <= '0;
      phase_r      <= PH_START;
      pending_r    <= '0;
      bytes_left_r <= '0;
      dest_r       <= '0;
      rows_r       <= '0;
      wptr_r       <= PTR_START;
      fill_r       <= '0;
      pair_half_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      flag_shift_r <= flag_shift_nxt;
      phase_r      <= phase_nxt;
      pending_r    <= pending_nxt;
      bytes_left_r <= bytes_left_nxt;
      dest_r       <= dest_nxt;
      rows_r       <= rows_nxt;
      wptr_r       <= wptr_nxt;
      fill_r       <= fill_nxt;
      pair_half_r  <= pair_half_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r          <= lit_nxt;
    src_r          <= src_nxt;
    len_r          <= len_nxt;
    pair_val_r     <= pair_val_nxt;
    pair_addr_r    <= pair_addr_nxt;
    o_first_val_r  <= o_first_val_nxt;
    o_first_addr_r <= o_first_addr_nxt;
    o_sec_val_r    <= o_sec_val_nxt;
    o_sec_addr_r   <= o_sec_addr_nxt;
    o_has2_r       <= o_has2_nxt;
    o_last_r       <= o_last_nxt;
    o_done_r       <= o_done_nxt;
  end

  // window RAM: write on emit, registered read on copy; entries past the fill count read as zero
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      win_mem[wptr_r] <= emit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= win_mem[src_r];
      rd_ok_r   <= ({1'b0, src_off} < fill_r);
    end
  end

  assign status.kind     = kind;
  assign status.out_free = !out_valid_r || out_tready;
  assign status.copy_end = copy_end;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_has2_r, o_sec_addr_r, o_sec_val_r, o_first_addr_r, o_first_val_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_done_r;

endmodule
`default_nettype wire

### sv/lz_window_decompressor.sv
// Top level: configuration registers, controller and datapath of the LZ window decompressor.
// Flag bytes and copy high bytes are taken in the idle state alone; a literal is taken, then emitted.
// A copy of up to 66 bytes takes its low byte, then for each byte a registered window RAM read
// followed by its write-back and emit; an emit waits while out_* still holds a pending result.
// A result is registered onto out_* in the cycle after its second (or final) byte is emitted.
// Reset is synchronous, active low; the window needs no clearing pass (a fill count masks it).
`default_nettype none
module lz_window_decompressor #(
  parameter int MAX_IMAGE_BYTES = 262144,
  parameter int MAX_STRIDE      = 512
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // in_tdata: [7:0] compressed_byte
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [7:0]                     in_tdata,
  // out_tdata: [7:0] first_value, [25:8] first_addr, [33:26] second_value,
  //            [51:34] second_addr, [52] has_second, [55:53] zero
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [lzwd_pkg::OUT_DW-1:0]    out_tdata,
  output logic                           out_tlast,
  // out_tuser: [0] image_done
  output logic                           out_tuser,
  input  wire                            cfg_psel,
  input  wire                            cfg_penable,
  input  wire                            cfg_pwrite,
  input  wire  [lzwd_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire  [lzwd_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [lzwd_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import lzwd_pkg::*;

  cfg_regs_t  cfg_r, cfg_nxt;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_BYTES:   cfg_nxt.image_bytes   = cfg_pwdata[IMG_W-1:0];
        REG_ROW_STRIDE:    cfg_nxt.row_stride    = cfg_pwdata[ROW_W-1:0];
        REG_COLUMN_HEIGHT: cfg_nxt.column_height = cfg_pwdata[ROW_W-1:0];
        REG_COLUMN_ORDER:  cfg_nxt.column_order  = cfg_pwdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_BYTES:   cfg_prdata = CFG_DW'(cfg_r.image_bytes);
      REG_ROW_STRIDE:    cfg_prdata = CFG_DW'(cfg_r.row_stride);
      REG_COLUMN_HEIGHT: cfg_prdata = CFG_DW'(cfg_r.column_height);
      REG_COLUMN_ORDER:  cfg_prdata = CFG_DW'(cfg_r.column_order);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_bytes   <= IMG_W'(1);
      cfg_r.row_stride    <= ROW_W'(1);
      cfg_r.column_height <= ROW_W'(1);
      cfg_r.column_order  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lzwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lzwd_datapath #(
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
    .MAX_STRIDE      (MAX_STRIDE)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("byte emitted while a result transaction is still pending");

  a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.emit || cmd.rd))
    else $error("window access while accepting input");

  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> !cmd.rd && !cmd.take_token)
    else $error("window read not followed by its write-back cycle");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("image done on a result that is not the last of its input");

endmodule
`default_nettype wire
